>>> design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the text console cursor block
// Result kinds, character codes, register indexes and the command record
// that travels from the front part to the back part through the queue.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Result kind carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Input operation carried on the input tuser.
  localparam logic FUNC_CHAR   = 1'b0;
  localparam logic FUNC_SETPOS = 1'b1;

  // Control characters.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  // Command queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // One queued command: a cell write (optionally preceded by a scroll beat)
  // or a set-position status.
  typedef struct packed {
    logic       scroll;
    kind_t      kind;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] glyph;
    logic       ok;
  } cmd_t;

  // Advance the row by one, saturating at the screen height.
  function automatic logic [7:0] next_row(input logic [7:0] row, input logic [7:0] rows);
    logic [8:0] r;
    r = {1'b0, row} + 9'd1;
    if (r > {1'b0, rows}) begin
      r = {1'b0, rows};
    end
    return r[7:0];
  endfunction

endpackage

>>> design/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front: item decode and cursor update
// Holds the screen size registers and the cursor, classifies each input item,
// updates the cursor in the cycle it is accepted and queues any results.
// ----------------------------------------------------------------------------
module tcc_front
  import tcc_pkg::*;
#(
  parameter int unsigned TAB_STOP = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_ch,
  input  logic [7:0]           in_col,
  input  logic [7:0]           in_row,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd
);

  localparam int unsigned TW = $clog2(256 + TAB_STOP);
  // Rounded-up reciprocal of the tab width in 16 fractional bits; exact for
  // every 8-bit column as long as the tab width stays at or below 256.
  localparam int unsigned TAB_RECIP = (65536 + TAB_STOP - 1) / TAB_STOP;

  logic [7:0]    columns;
  logic [7:0]    rows;
  logic [7:0]    cursor_col;
  logic [7:0]    cursor_row;
  logic [7:0]    cursor_col_next;
  logic [7:0]    cursor_row_next;
  logic          accept;
  logic [23:0]   tab_prod;
  logic [7:0]    tab_q;
  logic [TW+4:0] tab_full;
  logic [TW-1:0] tab_sum;
  logic          wrap;
  logic [7:0]    col_w;
  logic [7:0]    row_w;
  logic          scroll;
  logic [7:0]    row_p;
  logic          pos_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COLUMNS: columns <= cfg_wdata;
        REG_ROWS:    rows    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Next tab stop is one tab width past the start of the current tab field.
  // The field index comes from a reciprocal multiply; the sum may pass the
  // 8-bit range before the width check.
  assign tab_prod = 24'(cursor_col) * 24'(TAB_RECIP);
  assign tab_q    = tab_prod[23:16];
  assign tab_full = (TW+5)'({1'b0, tab_q} + 9'd1) * (TW+5)'(TAB_STOP);
  assign tab_sum  = tab_full[TW-1:0];

  // Printable byte: wrap first, then scroll if the row is off screen.
  assign wrap   = cursor_col >= columns;
  assign col_w  = wrap ? 8'd0 : cursor_col;
  assign row_w  = wrap ? next_row(cursor_row, rows) : cursor_row;
  assign scroll = row_w >= rows;
  assign row_p  = scroll ? ((rows == 8'd0) ? 8'd0 : rows - 8'd1) : row_w;

  assign pos_ok = (in_col < columns) && (in_row < rows);

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    q_push          = 1'b0;
    q_cmd           = '0;
    if (accept) begin
      if (in_func == FUNC_SETPOS) begin
        if (pos_ok) begin
          cursor_col_next = in_col;
          cursor_row_next = in_row;
        end
        q_push       = 1'b1;
        q_cmd.kind   = KIND_STATUS;
        q_cmd.row    = pos_ok ? in_row : cursor_row;
        q_cmd.col    = pos_ok ? in_col : cursor_col;
        q_cmd.ok     = pos_ok;
      end else if (in_ch == CH_NEWLINE) begin
        cursor_col_next = 8'd0;
        cursor_row_next = next_row(cursor_row, rows);
      end else if (in_ch == CH_TAB) begin
        if (tab_sum >= TW'(columns)) begin
          cursor_col_next = 8'd0;
          cursor_row_next = next_row(cursor_row, rows);
        end else begin
          cursor_col_next = tab_sum[7:0];
        end
      end else begin
        cursor_col_next = col_w + 8'd1;
        cursor_row_next = row_p;
        q_push          = 1'b1;
        q_cmd.scroll    = scroll;
        q_cmd.kind      = KIND_WRITE;
        q_cmd.row       = row_p;
        q_cmd.col       = col_w;
        q_cmd.glyph     = in_ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

>>> design/tcc_queue.sv
// ----------------------------------------------------------------------------
// tcc_queue: command queue between front and back
// A small first-in first-out store of commands; push and pop may coincide.
// ----------------------------------------------------------------------------
module tcc_queue
  import tcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = count == QCNT_W'(QDEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !(push && !pop))
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - QCNT_W'(1))
    else $error("queue count did not drop on pop");

endmodule

>>> design/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back: result beat generator
// Takes commands from the queue and drives the output stream, inserting a
// scroll beat ahead of a cell write that needs one.
// ----------------------------------------------------------------------------
module tcc_back
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  cmd_t        q_cmd,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic cur_valid;
  cmd_t cur;
  logic scroll_pending;
  logic beat_done;
  logic load;

  assign beat_done = cur_valid && m_tready;
  assign load      = !cur_valid || (m_tready && !scroll_pending);
  assign q_pop     = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid      <= 1'b0;
      scroll_pending <= 1'b0;
    end else if (load) begin
      cur_valid      <= q_valid;
      scroll_pending <= q_valid && q_cmd.scroll;
    end else if (beat_done) begin
      scroll_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  assign m_tvalid = cur_valid;
  assign m_tuser  = scroll_pending ? KIND_SCROLL : cur.kind;
  assign m_tlast  = !scroll_pending;
  assign m_tdata  = scroll_pending ? 32'd0 : {7'd0, cur.ok, cur.glyph, cur.col, cur.row};

  a_pending_valid: assert property (@(posedge clk) disable iff (rst)
    scroll_pending |-> cur_valid)
    else $error("scroll pending without a command");

  a_scroll_then_write: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && scroll_pending) |=> m_tvalid && m_tuser == KIND_WRITE)
    else $error("scroll beat not followed by its cell write");

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!cur_valid || (m_tready && !scroll_pending)))
    else $error("command taken while the output stage is busy");

endmodule

>>> design/text_console_cursor.sv
// ----------------------------------------------------------------------------
// text_console_cursor: cursor controller for a character-cell text console
// Tracks the cursor, turns a byte stream into cell writes and scrolls, and
// handles set-position requests with a status result.
// ----------------------------------------------------------------------------
// The block accepts one input beat per clock cycle. Newline and tab beats
// only move the cursor and produce no output beat. A printable byte produces
// one cell write beat, or two beats (a scroll with tlast low, then the cell
// write) when it lands below the last row. A set-position beat produces one
// status beat. The cursor is updated in the cycle the input beat is taken,
// and the results pass through a four-entry command queue to a one-beat
// registered output stage. The output stage delivers one beat per cycle
// while m_tready is high, which sets the sustained rate: one input per
// cycle when no scrolls occur, and one extra output beat for each scrolling
// byte. The input side stalls only when the queue is full. The column and
// row registers (indexes 0 and 1) reset to 80 by 25 and should be written
// only while no beat is in flight.
// ----------------------------------------------------------------------------
module text_console_cursor
  import tcc_pkg::*;
#(
  parameter int unsigned TAB_STOP = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]           cfg_wdata,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,  // ch [7:0], col_in [15:8], row_in [23:16]
  input  logic [0:0]           s_tuser,  // func [0]
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,  // row [7:0], col [15:8], glyph [23:16], ok [24]
  output logic [1:0]           m_tuser,  // kind [1:0]
  output logic                 m_tlast
);

  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_pop_cmd;

  // Decode and cursor update.
  tcc_front #(
    .TAB_STOP(TAB_STOP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser[0]),
    .in_ch    (s_tdata[7:0]),
    .in_col   (s_tdata[15:8]),
    .in_row   (s_tdata[23:16]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  // Decouples the cursor update from output backpressure.
  tcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd)
  );

  // Beat generation, including the extra scroll beat.
  tcc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_pop_cmd),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // A scroll beat never ends the results of its byte.
  a_scroll_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_SCROLL) |-> !m_tlast && m_tdata == 32'd0)
    else $error("scroll beat with payload or tlast");

  // Status and cell write beats always close their input's results.
  a_final_kinds_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_STATUS || m_tuser == KIND_WRITE)) |-> m_tlast)
    else $error("final beat without tlast");

  // Input is refused only when the queue has no room.
  a_ready_follows_queue: assert property (@(posedge clk) disable iff (rst)
    s_tready == !q_full)
    else $error("input ready does not follow queue space");

endmodule
